### design/linear_queue_with_reverse_unit_assert.svh
// Assertion macros for the linear queue block and its port checker.
// Expects i_clk and i_rst_n in the scope of each use.
`ifndef LINEAR_QUEUE_WITH_REVERSE_UNIT_ASSERT_SVH
`define LINEAR_QUEUE_WITH_REVERSE_UNIT_ASSERT_SVH

// same-cycle implication
`define LQR_ASSERT_IMP(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication
`define LQR_ASSERT_NXT(name, ante, cons, msg) \
    name: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### design/lqr_pkg.sv
// Shared types and codes for the linear queue with reverse.
// No dependencies.
package lqr_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 5;

    localparam logic [1:0] KIND_ENQ = 2'd0;
    localparam logic [1:0] KIND_DEQ = 2'd1;
    localparam logic [1:0] KIND_REV = 2'd2;

    localparam logic [1:0] ST_DONE     = 2'd0;
    localparam logic [1:0] ST_OVERFLOW = 2'd1;
    localparam logic [1:0] ST_EMPTY    = 2'd2;

    localparam logic signed [WORD_W-1:0] EMPTY_WORD = '1;

    typedef struct packed {
        logic [1:0]                kind;
        logic signed [WORD_W-1:0]  word_in;
    } t_in_item;

    typedef struct packed {
        logic [1:0]                status;
        logic signed [WORD_W-1:0]  word_out;
        logic [OCC_W-1:0]          occupancy;
    } t_out_item;

endpackage

### design/linear_queue_with_reverse_unit.sv
// Linear queue with reverse: top level with the word store and its sequencer; uses lqr_pkg.
// Enqueue, no-op, empty dequeue or a reverse with nothing to move are answered from idle; a dequeue
// that returns a word first reads the store (S_DEQ). A reverse of n words copies them down to slot 0
// when the head is not at slot 0 (S_SH_RD, S_SH_WR), then swaps pairs (S_SW_RLO/RHI/WLO/WHI).
// Throughput: one item at a time; the next transfers once the sequencer is idle and the result
// register is free. Reset (synchronous, active low) empties the queue; store contents undefined.
module linear_queue_with_reverse_unit
    import lqr_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    output logic      o_in_ready,
    input  t_in_item  i_in_item,
    output logic      o_out_valid,
    input  logic      i_out_ready,
    output t_out_item o_out_item
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = (AW + 1 > OCC_W) ? AW + 1 : OCC_W;
    localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DEQ,
        S_SH_RD,
        S_SH_WR,
        S_SW_RLO,
        S_SW_RHI,
        S_SW_WLO,
        S_SW_WHI
    } t_state;

    t_state            r_state, n_state;
    logic [AW-1:0]     r_head, n_head;
    logic [AW-1:0]     r_tail, n_tail;
    logic              r_empty, n_empty;
    logic [AW-1:0]     r_a, n_a;
    logic [AW-1:0]     r_b, n_b;
    logic [WORD_W-1:0] r_tmp, n_tmp;
    logic              r_ovalid, n_ovalid;
    t_out_item         r_out, n_out;

    logic [WORD_W-1:0] mem [DEPTH];
    logic [WORD_W-1:0] r_rdata;
    logic              mem_we;
    logic [AW-1:0]     mem_waddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [AW-1:0]     mem_raddr;

    logic              in_fire;
    logic              done;
    logic [1:0]        res_status;
    logic [WORD_W-1:0] res_word;

    function automatic logic [OCC_W-1:0] occ(input logic [AW-1:0] head,
                                             input logic [AW-1:0] tail,
                                             input logic empty);
        logic [CW-1:0] cnt;
        cnt = CW'(tail) - CW'(head) + CW'(1);
        return empty ? '0 : cnt[OCC_W-1:0];
    endfunction

    assign o_in_ready  = (r_state == S_IDLE) && (!r_ovalid || i_out_ready);
    assign in_fire     = i_in_valid && o_in_ready;
    assign o_out_valid = r_ovalid;
    assign o_out_item  = r_out;

    always_comb begin
        n_state    = r_state;
        n_head     = r_head;
        n_tail     = r_tail;
        n_empty    = r_empty;
        n_a        = r_a;
        n_b        = r_b;
        n_tmp      = r_tmp;
        n_ovalid   = r_ovalid && !i_out_ready;
        n_out      = r_out;
        mem_we     = 1'b0;
        mem_waddr  = r_a;
        mem_wdata  = r_rdata;
        mem_raddr  = r_a;
        done       = 1'b0;
        res_status = ST_DONE;
        res_word   = '0;
        case (r_state)
            S_IDLE: begin
                if (in_fire) begin
                    case (i_in_item.kind)
                        KIND_ENQ: begin
                            done = 1'b1;
                            if (r_empty) begin
                                n_head    = '0;
                                n_tail    = '0;
                                n_empty   = 1'b0;
                                mem_we    = 1'b1;
                                mem_waddr = '0;
                                mem_wdata = i_in_item.word_in;
                            end else if (r_tail == LAST) begin
                                res_status = ST_OVERFLOW;
                            end else begin
                                n_tail    = r_tail + AW'(1);
                                mem_we    = 1'b1;
                                mem_waddr = r_tail + AW'(1);
                                mem_wdata = i_in_item.word_in;
                            end
                        end
                        KIND_DEQ: begin
                            if (r_empty) begin
                                done       = 1'b1;
                                res_status = ST_EMPTY;
                                res_word   = EMPTY_WORD;
                            end else begin
                                mem_raddr = r_head;
                                n_state   = S_DEQ;
                            end
                        end
                        KIND_REV: begin
                            if (r_empty) begin
                                done = 1'b1;
                            end else if (r_head != '0) begin
                                n_a     = r_head;
                                n_b     = '0;
                                n_state = S_SH_RD;
                            end else if (r_tail != '0) begin
                                n_a     = '0;
                                n_b     = r_tail;
                                n_state = S_SW_RLO;
                            end else begin
                                done = 1'b1;
                            end
                        end
                        default: begin
                            done = 1'b1;
                        end
                    endcase
                end
            end
            S_DEQ: begin
                done     = 1'b1;
                res_word = r_rdata;
                n_state  = S_IDLE;
                if (r_head == r_tail) begin
                    n_empty = 1'b1;
                    n_head  = '0;
                    n_tail  = '0;
                end else begin
                    n_head = r_head + AW'(1);
                end
            end
            S_SH_RD: begin
                mem_raddr = r_a;
                n_state   = S_SH_WR;
            end
            S_SH_WR: begin
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = r_rdata;
                if (r_b == r_tail - r_head) begin
                    n_head = '0;
                    n_tail = r_b;
                    if (r_b != '0) begin
                        n_a     = '0;
                        n_b     = r_b;
                        n_state = S_SW_RLO;
                    end else begin
                        done    = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    n_a     = r_a + AW'(1);
                    n_b     = r_b + AW'(1);
                    n_state = S_SH_RD;
                end
            end
            S_SW_RLO: begin
                mem_raddr = r_a;
                n_state   = S_SW_RHI;
            end
            S_SW_RHI: begin
                mem_raddr = r_b;
                n_tmp     = r_rdata;
                n_state   = S_SW_WLO;
            end
            S_SW_WLO: begin
                mem_we    = 1'b1;
                mem_waddr = r_a;
                mem_wdata = r_rdata;
                n_state   = S_SW_WHI;
            end
            S_SW_WHI: begin
                mem_we    = 1'b1;
                mem_waddr = r_b;
                mem_wdata = r_tmp;
                if ({1'b0, r_b - r_a} > (AW + 1)'(2)) begin
                    n_a     = r_a + AW'(1);
                    n_b     = r_b - AW'(1);
                    n_state = S_SW_RLO;
                end else begin
                    done    = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
        if (done) begin
            n_ovalid        = 1'b1;
            n_out.status    = res_status;
            n_out.word_out  = res_word;
            n_out.occupancy = occ(n_head, n_tail, n_empty);
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
        r_rdata <= mem[mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_head   <= '0;
            r_tail   <= '0;
            r_empty  <= 1'b1;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_head   <= n_head;
            r_tail   <= n_tail;
            r_empty  <= n_empty;
            r_ovalid <= n_ovalid;
        end
        r_a   <= n_a;
        r_b   <= n_b;
        r_tmp <= n_tmp;
        r_out <= n_out;
    end

endmodule

### design/lqr_checker.sv
// Port checker for the linear queue with reverse, bound to the top level.
// Depends on lqr_pkg and linear_queue_with_reverse_unit_assert.svh.
`include "linear_queue_with_reverse_unit_assert.svh"

module lqr_checker
    import lqr_pkg::*;
(
    input logic      i_clk,
    input logic      i_rst_n,
    input logic      i_in_valid,
    input logic      o_in_ready,
    input t_in_item  i_in_item,
    input logic      o_out_valid,
    input logic      i_out_ready,
    input t_out_item o_out_item
);

    `LQR_ASSERT_NXT(a_out_hold, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_item), "result changed while stalled")
    `LQR_ASSERT_IMP(a_stall_in, o_out_valid && !i_out_ready, !o_in_ready, "input taken while result stalled")
    `LQR_ASSERT_IMP(a_empty_word, o_out_valid && o_out_item.status == ST_EMPTY, o_out_item.word_out == EMPTY_WORD && o_out_item.occupancy == '0, "empty dequeue result malformed")
    `LQR_ASSERT_IMP(a_ovf_word, o_out_valid && o_out_item.status == ST_OVERFLOW, o_out_item.word_out == '0 && o_out_item.occupancy != '0, "overflow result malformed")

endmodule

bind linear_queue_with_reverse_unit lqr_checker u_lqr_checker (.*);
